FILE: rtl/nmea_gga_rmc_field_extractor_macros.svh
// Assertion macros used by the checker file.
`ifndef NMEA_GGA_RMC_FIELD_EXTRACTOR_MACROS_SVH
`define NMEA_GGA_RMC_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define NMEAX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define NMEAX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/nmeax_pkg.sv
package nmeax_pkg;

   // Longest line, newline included, that is parsed in full.
   localparam int LINE_BYTES = 128;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte classes decided by the front end.
   localparam logic [1:0] CLS_DATA    = 2'd0;
   localparam logic [1:0] CLS_NEWLINE = 2'd1;
   localparam logic [1:0] CLS_COMMA   = 2'd2;
   localparam logic [1:0] CLS_ZERO    = 2'd3;

   // Sentence kinds reported on the result channel.
   localparam logic [1:0] KIND_GGA   = 2'd0;
   localparam logic [1:0] KIND_RMC   = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   // Characters of interest.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] DIGIT_ZERO   = 8'd48;

   // Line positions that carry the sentence address.
   localparam logic [7:0] POS_TALKER = 8'd1;
   localparam logic [7:0] POS_TYPE1  = 8'd3;
   localparam logic [7:0] POS_TYPE2  = 8'd4;

   // Token numbers that update stored data.
   localparam logic [3:0] TOK_GGA_LAT  = 4'd2;
   localparam logic [3:0] TOK_GGA_LON  = 4'd4;
   localparam logic [3:0] TOK_GGA_QUAL = 4'd6;
   localparam logic [3:0] TOK_GGA_ALT  = 4'd9;
   localparam logic [3:0] TOK_RMC_STAT = 4'd2;
   localparam logic [3:0] TOK_RMC_LAT  = 4'd3;
   localparam logic [3:0] TOK_RMC_LON  = 4'd5;

   typedef struct packed {
      logic [1:0] cls;
      logic [7:0] data;
   } item_type;

endpackage

FILE: rtl/nmeax_front.sv
module nmeax_front
   import nmeax_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   item_type                 new_item;
   logic                     push;

   // Classify the byte on the way in so the parser only looks at a code.
   always_comb begin
      new_item.data = req_rx_byte;
      if (req_rx_byte == CHAR_NEWLINE) begin
         new_item.cls = CLS_NEWLINE;
      end else if (req_rx_byte == CHAR_COMMA) begin
         new_item.cls = CLS_COMMA;
      end else if (req_rx_byte == CHAR_NUL) begin
         new_item.cls = CLS_ZERO;
      end else begin
         new_item.cls = CLS_DATA;
      end
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/nmeax_back.sv
module nmeax_back
   import nmeax_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_sentence_kind,
   output logic [6:0]  rsp_latitude_deg,
   output logic [6:0]  rsp_longitude_lead,
   output logic [3:0]  rsp_fix_quality,
   output logic [15:0] rsp_altitude_value,
   output logic        rsp_fix_valid
);

   // Line state.
   logic [7:0]  pos_ff, pos_in;
   logic        talker_p_ff, talker_p_in;
   logic        type1_g_ff, type1_g_in;
   logic        type1_r_ff, type1_r_in;
   logic        type2_g_ff, type2_g_in;
   logic [3:0]  tok_idx_ff, tok_idx_in;
   logic [7:0]  tok_len_ff, tok_len_in;
   logic [15:0] tok_lead_ff, tok_lead_in;
   logic [15:0] alt_acc_ff, alt_acc_in;
   logic [15:0] lag_ff, lag_in;
   logic        stopped_ff, stopped_in;
   logic        overflow_ff, overflow_in;
   // Values kept across lines.
   logic [6:0]  lat_ff, lat_in;
   logic [6:0]  lon_ff, lon_in;
   logic [3:0]  qual_ff, qual_in;
   logic [15:0] alt_ff, alt_in;
   logic        fixv_ff, fixv_in;
   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [6:0]  out_lat_ff, out_lat_in;
   logic [6:0]  out_lon_ff, out_lon_in;
   logic [3:0]  out_qual_ff, out_qual_in;
   logic [15:0] out_alt_ff, out_alt_in;
   logic        out_fixv_ff, out_fixv_in;

   logic        newline;
   logic        over_limit;
   logic        is_gga;
   logic        is_rmc;
   logic        close_tok;
   logic [7:0]  c0;
   logic [7:0]  c1;
   logic [6:0]  lead7;

   assign newline    = (q_item.cls == CLS_NEWLINE);
   assign over_limit = ({1'b0, pos_ff} >= 9'(LINE_BYTES - 1));
   // A newline needs the result register; other bytes never wait.
   assign q_pop      = q_valid && (!newline || !rsp_valid_ff || rsp_ready);

   always_comb begin
      pos_in       = pos_ff;
      talker_p_in  = talker_p_ff;
      type1_g_in   = type1_g_ff;
      type1_r_in   = type1_r_ff;
      type2_g_in   = type2_g_ff;
      tok_idx_in   = tok_idx_ff;
      tok_len_in   = tok_len_ff;
      tok_lead_in  = tok_lead_ff;
      alt_acc_in   = alt_acc_ff;
      lag_in       = lag_ff;
      stopped_in   = stopped_ff;
      overflow_in  = overflow_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      qual_in      = qual_ff;
      alt_in       = alt_ff;
      fixv_in      = fixv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      out_lat_in   = out_lat_ff;
      out_lon_in   = out_lon_ff;
      out_qual_in  = out_qual_ff;
      out_alt_in   = out_alt_ff;
      out_fixv_in  = out_fixv_ff;
      is_gga       = 1'b0;
      is_rmc       = 1'b0;
      close_tok    = 1'b0;
      c0           = '0;
      c1           = '0;
      lead7        = '0;

      if (q_pop) begin
         if (!newline && over_limit) begin
            overflow_in = 1'b1;
            stopped_in  = 1'b1;
         end else begin
            if (pos_ff == POS_TALKER) begin
               talker_p_in = (q_item.data == CHAR_P);
            end else if (pos_ff == POS_TYPE1) begin
               type1_g_in = (q_item.data == CHAR_G);
               type1_r_in = (q_item.data == CHAR_R);
            end else if (pos_ff == POS_TYPE2) begin
               type2_g_in = (q_item.data == CHAR_G);
            end
            is_gga = !talker_p_in && type1_g_in && type2_g_in;
            is_rmc = !talker_p_in && type1_r_in;

            if ((pos_ff == POS_TYPE2 || (newline && pos_ff < POS_TYPE2)) && is_rmc) begin
               fixv_in = 1'b1;
            end

            if (!stopped_ff) begin
               unique case (q_item.cls) inside
                  CLS_COMMA: begin
                     close_tok = (tok_len_ff != '0);
                  end
                  CLS_ZERO: begin
                     close_tok  = (tok_len_ff != '0);
                     stopped_in = 1'b1;
                  end
                  CLS_DATA, CLS_NEWLINE: begin
                     if (tok_len_ff == '0) begin
                        tok_lead_in = {q_item.data, 8'h00};
                        alt_acc_in  = '0;
                     end else if (tok_len_ff == 8'd1) begin
                        tok_lead_in = {tok_lead_ff[15:8], q_item.data};
                     end else begin
                        alt_acc_in = 16'(alt_acc_ff * 16'd10 + {8'h00, lag_ff[15:8]}
                                         - {8'h00, DIGIT_ZERO});
                     end
                     lag_in = {(tok_len_ff == '0) ? 8'h00 : lag_ff[7:0], q_item.data};
                     if (tok_len_ff != 8'hFF) begin
                        tok_len_in = tok_len_ff + 8'd1;
                     end
                     close_tok = newline;
                  end
                  default: begin
                     close_tok = 1'b0;
                  end
               endcase

               if (close_tok) begin
                  c0    = tok_lead_in[15:8];
                  c1    = tok_lead_in[7:0];
                  // Two leading digits; the ASCII offset of both folds into one constant.
                  lead7 = 7'({8'h00, c0} * 16'd10 + {8'h00, c1} - 16'({8'h00, DIGIT_ZERO} * 16'd11));
                  if (is_gga) begin
                     if (tok_idx_ff == TOK_GGA_LAT) begin
                        lat_in = lead7;
                     end else if (tok_idx_ff == TOK_GGA_LON) begin
                        lon_in = lead7;
                     end else if (tok_idx_ff == TOK_GGA_QUAL) begin
                        qual_in = c0[3:0];
                     end else if (tok_idx_ff == TOK_GGA_ALT) begin
                        alt_in = (tok_len_in >= 8'd3) ? 16'(alt_acc_in * 16'd10) : '0;
                     end
                  end else if (is_rmc) begin
                     if (tok_idx_ff == TOK_RMC_STAT) begin
                        if (c0 == CHAR_V) begin
                           fixv_in    = 1'b0;
                           stopped_in = 1'b1;
                        end
                     end else if (tok_idx_ff == TOK_RMC_LAT) begin
                        lat_in = lead7;
                     end else if (tok_idx_ff == TOK_RMC_LON) begin
                        lon_in = lead7;
                     end
                  end
                  if (!(&tok_idx_ff)) begin
                     tok_idx_in = tok_idx_ff + 4'd1;
                  end
                  tok_len_in  = '0;
                  tok_lead_in = '0;
                  alt_acc_in  = '0;
                  lag_in      = '0;
               end
            end

            if (pos_ff != 8'hFF) begin
               pos_in = pos_ff + 8'd1;
            end

            if (newline) begin
               rsp_valid_in = 1'b1;
               kind_in      = overflow_ff ? KIND_OTHER :
                              (is_gga ? KIND_GGA : (is_rmc ? KIND_RMC : KIND_OTHER));
               out_lat_in   = lat_in;
               out_lon_in   = lon_in;
               out_qual_in  = qual_in;
               out_alt_in   = alt_in;
               out_fixv_in  = fixv_in;
               pos_in       = '0;
               talker_p_in  = 1'b0;
               type1_g_in   = 1'b0;
               type1_r_in   = 1'b0;
               type2_g_in   = 1'b0;
               tok_idx_in   = '0;
               tok_len_in   = '0;
               tok_lead_in  = '0;
               alt_acc_in   = '0;
               lag_in       = '0;
               stopped_in   = 1'b0;
               overflow_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         talker_p_ff  <= 1'b0;
         type1_g_ff   <= 1'b0;
         type1_r_ff   <= 1'b0;
         type2_g_ff   <= 1'b0;
         tok_idx_ff   <= '0;
         tok_len_ff   <= '0;
         tok_lead_ff  <= '0;
         alt_acc_ff   <= '0;
         lag_ff       <= '0;
         stopped_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         lat_ff       <= '0;
         lon_ff       <= '0;
         qual_ff      <= '0;
         alt_ff       <= '0;
         fixv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         talker_p_ff  <= talker_p_in;
         type1_g_ff   <= type1_g_in;
         type1_r_ff   <= type1_r_in;
         type2_g_ff   <= type2_g_in;
         tok_idx_ff   <= tok_idx_in;
         tok_len_ff   <= tok_len_in;
         tok_lead_ff  <= tok_lead_in;
         alt_acc_ff   <= alt_acc_in;
         lag_ff       <= lag_in;
         stopped_ff   <= stopped_in;
         overflow_ff  <= overflow_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         qual_ff      <= qual_in;
         alt_ff       <= alt_in;
         fixv_ff      <= fixv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      out_lat_ff  <= out_lat_in;
      out_lon_ff  <= out_lon_in;
      out_qual_ff <= out_qual_in;
      out_alt_ff  <= out_alt_in;
      out_fixv_ff <= out_fixv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sentence_kind  = kind_ff;
   assign rsp_latitude_deg   = out_lat_ff;
   assign rsp_longitude_lead = out_lon_ff;
   assign rsp_fix_quality    = out_qual_ff;
   assign rsp_altitude_value = out_alt_ff;
   assign rsp_fix_valid      = out_fixv_ff;

endmodule

FILE: rtl/nmea_gga_rmc_field_extractor.sv
// NMEA GGA/RMC field extractor.
// The req channel carries the receiver text, one character per transfer on
// req_rx_byte. Each line ends in a newline; for every newline one transfer
// appears on the rsp channel with the sentence kind (GGA, RMC or other) and
// the stored latitude lead, longitude lead, fix quality, altitude times ten
// and RMC fix status. Other characters produce no result.
// The front end classifies each character and writes it into a two-entry
// queue; the back end parses one character per cycle out of that queue,
// unless a newline waits for an earlier result to leave rsp, and loads a
// result register on a newline. While rsp is not stalled, one character is
// accepted per cycle sustained. A newline passes the queue and the result
// register on its way to rsp. When the receiver stalls, the pending result
// holds steady, the parser keeps consuming characters until it reaches the
// next newline, and req_ready drops once the queue fills behind it.
// Synchronous reset empties the queue, drops rsp_valid, starts a new line
// and clears all stored position data to zero.
module nmea_gga_rmc_field_extractor
   import nmeax_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_sentence_kind,
   output logic [6:0]  rsp_latitude_deg,
   output logic [6:0]  rsp_longitude_lead,
   output logic [3:0]  rsp_fix_quality,
   output logic [15:0] rsp_altitude_value,
   output logic        rsp_fix_valid
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // Character classification and the queue that decouples the two halves.
   nmeax_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // Line parser, stored position data and the result register.
   nmeax_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_latitude_deg   (rsp_latitude_deg),
      .rsp_longitude_lead (rsp_longitude_lead),
      .rsp_fix_quality    (rsp_fix_quality),
      .rsp_altitude_value (rsp_altitude_value),
      .rsp_fix_valid      (rsp_fix_valid)
   );

endmodule

FILE: rtl/nmeax_checker.sv
`include "nmea_gga_rmc_field_extractor_macros.svh"

module nmeax_checker
   import nmeax_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_sentence_kind,
   input logic [6:0]  rsp_latitude_deg,
   input logic [6:0]  rsp_longitude_lead,
   input logic [3:0]  rsp_fix_quality,
   input logic [15:0] rsp_altitude_value,
   input logic        rsp_fix_valid
);

   logic nl_in;

   assign nl_in = req_valid && req_ready && (req_rx_byte == CHAR_NEWLINE);

   // A pending result is not withdrawn.
   `NMEAX_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A pending result keeps its payload.
   `NMEAX_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_sentence_kind) && $stable(rsp_latitude_deg) && $stable(rsp_longitude_lead)
      && $stable(rsp_fix_quality) && $stable(rsp_altitude_value) && $stable(rsp_fix_valid))

   // Only the three defined sentence kinds are reported.
   `NMEAX_ASSERT_NOW(a_kind_legal, clock, reset, rsp_valid,
      rsp_sentence_kind == KIND_GGA || rsp_sentence_kind == KIND_RMC
      || rsp_sentence_kind == KIND_OTHER)

   // Reset clears any pending result.
   `NMEAX_ASSERT_NEXT(a_no_early_rsp, clock, 1'b0, reset, !rsp_valid)

   // With an empty pipeline a newline yields a result through the queue and the result register.
   `NMEAX_ASSERT_NEXT(a_nl_result, clock, reset,
      nl_in && !rsp_valid && $past(!req_valid || !req_ready) && !$past(reset),
      ##1 rsp_valid)

endmodule

bind nmea_gga_rmc_field_extractor nmeax_checker u_nmeax_checker (.*);
